[src/mrh_pkg.sv]
// ============================================================================
// mrh_pkg - mesh route hop generator shared types and constants
// Item formats, operation/mode/direction codes, controller-datapath bundles.
// ============================================================================
package mrh_pkg;

	// Coordinate field width, fixed by the item format
	localparam int COORD_W = 3;

	// Parameter defaults
	localparam int ROWS_DEF        = 8;
	localparam int COLS_DEF        = 8;
	localparam int WEIGHT_BITS_DEF = 16;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_ROUTE = 1'b1;

	// Routing modes
	localparam logic [1:0] MODE_XY  = 2'd0;
	localparam logic [1:0] MODE_YX  = 2'd1;
	localparam logic [1:0] MODE_BAL = 2'd2;
	localparam logic [1:0] MODE_ADP = 2'd3;

	// Hop / link directions
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] src_row;
		logic [COORD_W-1:0] src_col;
		logic [COORD_W-1:0] dst_row;
		logic [COORD_W-1:0] dst_col;
		logic [15:0]        penalty;
		logic [1:0]         link_dir;
		logic [15:0]        link_weight;
	} mrh_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] from_row;
		logic [COORD_W-1:0] from_col;
		logic [COORD_W-1:0] to_row;
		logic [COORD_W-1:0] to_col;
		logic [1:0]         hop_dir;
		logic [15:0]        hop_penalty;
		logic               last_hop;
	} mrh_hop_t;

	// Controller -> datapath
	typedef struct packed {
		logic clr;   // clearing pass: zero one weight entry
		logic load;  // item accepted: capture it, store weight on a write
		logic step;  // emit one hop and advance
	} mrh_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;  // clearing pass is at its final entry
		logic route_go;  // item on the request port is a route with hops
		logic adaptive;  // weight-based mode selected
		logic last;      // hop being formed ends at the destination
	} mrh_sts_t;

endpackage

[src/mrh_ram.sv]
// ============================================================================
// mrh_ram - generic RAM, one write port, two registered read ports
// ============================================================================
module mrh_ram
	#(
		parameter int WIDTH = 16,
		parameter int DEPTH = 256
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic [$clog2(DEPTH)-1:0] raddr_a,
		output logic [WIDTH-1:0]         rdata_a,
		input  logic [$clog2(DEPTH)-1:0] raddr_b,
		output logic [WIDTH-1:0]         rdata_b
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[src/mrh_ctrl.sv]
// ============================================================================
// mrh_ctrl - sequencer for the mesh route hop generator
// Runs the post-reset clearing pass, accepts items, paces hop emission.
// ============================================================================
module mrh_ctrl
	import mrh_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     start,
		input  mrh_sts_t sts,
		output mrh_cmd_t cmd,
		output logic     busy
	);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_ADP_RD,
		S_ADP_HOP
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && !busy_q) begin
					cmd.load = 1'b1;
					if (sts.route_go) begin
						state_d = sts.adaptive ? S_ADP_RD : S_WALK;
					end
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = S_IDLE;
				end
			end
			S_ADP_RD: begin
				// weights of the current node are read this cycle
				state_d = S_ADP_HOP;
			end
			S_ADP_HOP: begin
				cmd.step = 1'b1;
				state_d  = sts.last ? S_IDLE : S_ADP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

[src/mrh_dp.sv]
// ============================================================================
// mrh_dp - datapath for the mesh route hop generator
// Mode register, link weight memory, position registers, hop formation.
// ============================================================================
module mrh_dp
	import mrh_pkg::*;
	#(
		parameter int ROWS        = ROWS_DEF,
		parameter int COLS        = COLS_DEF,
		parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		input  mrh_req_t   req,
		input  logic       cfg_we,
		input  logic [1:0] cfg_wdata,
		input  mrh_cmd_t   cmd,
		output mrh_sts_t   sts,
		output logic       result_valid,
		output mrh_hop_t   result
	);

	localparam int DEPTH  = ROWS * COLS * 4;
	localparam int ADDR_W = $clog2(DEPTH);

	function automatic logic [ADDR_W-1:0] link_addr(
		input logic [COORD_W-1:0] r,
		input logic [COORD_W-1:0] c,
		input logic [1:0]         d
	);
		return ADDR_W'((int'(r) * COLS + int'(c)) * 4 + int'(d));
	endfunction

	logic [1:0]             mode_q;
	logic [ADDR_W-1:0]      clr_cnt_q;
	logic [COORD_W-1:0]     cur_r_q, cur_c_q, dst_r_q, dst_c_q;
	logic [15:0]            pen_q;
	logic                   cols_first_q;
	logic                   res_valid_q;
	mrh_hop_t               res_q;

	logic                   src_ok, dst_ok;
	logic [COORD_W-1:0]     ax, ay;
	logic                   cols_first_d;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic [WEIGHT_BITS-1:0] wx, wy;
	logic [1:0]             dir_x, dir_y, dir_dor, dir_adp, dir_step;
	logic                   need_x, need_y;
	logic [COORD_W-1:0]     nxt_r, nxt_c;

	// ---- item decode ----
	assign src_ok = (int'(req.src_row) < ROWS) && (int'(req.src_col) < COLS);
	assign dst_ok = (int'(req.dst_row) < ROWS) && (int'(req.dst_col) < COLS);

	assign ax = (req.src_col >= req.dst_col) ? req.src_col - req.dst_col
	                                         : req.dst_col - req.src_col;
	assign ay = (req.src_row >= req.dst_row) ? req.src_row - req.dst_row
	                                         : req.dst_row - req.src_row;

	always_comb begin
		unique case (mode_q)
			MODE_XY:  cols_first_d = 1'b1;
			MODE_YX:  cols_first_d = 1'b0;
			MODE_BAL: begin
				if (ax == '0)      cols_first_d = 1'b1;
				else if (ay == '0) cols_first_d = 1'b0;
				else if (ax > ay)  cols_first_d = 1'b0;
				else if (ax < ay)  cols_first_d = 1'b1;
				else               cols_first_d = ~ax[0];
			end
			MODE_ADP: cols_first_d = 1'b1;
			default:  cols_first_d = 1'b1;
		endcase
	end

	// ---- weight memory; clearing pass owns the write port until done ----
	assign ram_we    = cmd.clr || (cmd.load && req.operation == OP_WRITE && src_ok);
	assign ram_waddr = cmd.clr ? clr_cnt_q
	                           : link_addr(req.src_row, req.src_col, req.link_dir);
	assign ram_wdata = cmd.clr ? '0 : WEIGHT_BITS'(req.link_weight);

	// ---- hop direction ----
	assign need_x = (cur_c_q != dst_c_q);
	assign need_y = (cur_r_q != dst_r_q);
	assign dir_x  = (cur_c_q < dst_c_q) ? DIR_E : DIR_W;
	assign dir_y  = (cur_r_q < dst_r_q) ? DIR_S : DIR_N;

	mrh_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_weights (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (link_addr(cur_r_q, cur_c_q, dir_x)),
		.rdata_a (wx),
		.raddr_b (link_addr(cur_r_q, cur_c_q, dir_y)),
		.rdata_b (wy)
	);

	always_comb begin
		if (cols_first_q) dir_dor = need_x ? dir_x : dir_y;
		else              dir_dor = need_y ? dir_y : dir_x;
		// tie on both axes: column step wins unless its link is heavier
		if (need_x && need_y) dir_adp = (wx <= wy) ? dir_x : dir_y;
		else if (need_x)      dir_adp = dir_x;
		else                  dir_adp = dir_y;
		dir_step = (mode_q == MODE_ADP) ? dir_adp : dir_dor;
	end

	always_comb begin
		nxt_r = cur_r_q;
		nxt_c = cur_c_q;
		case (dir_step)
			DIR_N:   nxt_r = cur_r_q - COORD_W'(1);
			DIR_S:   nxt_r = cur_r_q + COORD_W'(1);
			DIR_E:   nxt_c = cur_c_q + COORD_W'(1);
			default: nxt_c = cur_c_q - COORD_W'(1);
		endcase
	end

	// ---- status ----
	assign sts.clr_last = (clr_cnt_q == ADDR_W'(DEPTH - 1));
	assign sts.route_go = (req.operation == OP_ROUTE) && src_ok && dst_ok &&
	                      ((req.src_row != req.dst_row) || (req.src_col != req.dst_col));
	assign sts.adaptive = (mode_q == MODE_ADP);
	assign sts.last     = (nxt_r == dst_r_q) && (nxt_c == dst_c_q);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_XY;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			res_valid_q <= cmd.step;
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_r_q      <= req.src_row;
			cur_c_q      <= req.src_col;
			dst_r_q      <= req.dst_row;
			dst_c_q      <= req.dst_col;
			pen_q        <= req.penalty;
			cols_first_q <= cols_first_d;
		end else if (cmd.step) begin
			cur_r_q <= nxt_r;
			cur_c_q <= nxt_c;
		end
		if (cmd.step) begin
			res_q.from_row    <= cur_r_q;
			res_q.from_col    <= cur_c_q;
			res_q.to_row      <= nxt_r;
			res_q.to_col      <= nxt_c;
			res_q.hop_dir     <= dir_step;
			res_q.hop_penalty <= (mode_q == MODE_ADP) ? 16'd0 : pen_q;
			res_q.last_hop    <= sts.last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[src/mesh_route_hop_generator.sv]
// ============================================================================
// mesh_route_hop_generator - 2D mesh route expansion into hops
// Holds per-link weights, expands a route request into its hops in
// XY, YX, balanced dimension order or weight-based minimal adaptive order.
// ============================================================================
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+-----------------------------
//  request   | start, busy, req              | taken when start && !busy
//  result    | result_valid, result          | one-cycle strobe, no stall
//  config    | cfg_we, cfg_wdata             | routing mode, written on cfg_we
//
// Sequencing: a weight write leaves busy low. A route of n hops
// (n = row distance + column distance) in XY, YX or balanced mode
// holds busy while it emits one hop per cycle; in adaptive mode each
// hop waits on the registered read of the current node's two
// candidate link weights. The last hop shows in the cycle busy drops, and
// a new item may be taken in that same cycle.
// Reset: arst_n clears the mode to XY and starts a clearing pass over
// all ROWS*COLS*4 entries (256 at 8x8) that zeroes every link weight;
// busy is high until it ends.
// Stalls: none on the result side; results are strobed and must be taken.
//
module mesh_route_hop_generator
	import mrh_pkg::*;
	#(
		parameter int ROWS        = ROWS_DEF,
		parameter int COLS        = COLS_DEF,
		parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		// request item
		input  logic       start,
		output logic       busy,
		input  mrh_req_t   req,
		// routing mode register
		input  logic       cfg_we,
		input  logic [1:0] cfg_wdata,
		// hop results
		output logic       result_valid,
		output mrh_hop_t   result
	);

	mrh_cmd_t cmd;
	mrh_sts_t sts;

	// Sequencer: clearing pass, item acceptance, hop pacing
	mrh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: weights, walk position, hop output register
	mrh_dp #(
		.ROWS        (ROWS),
		.COLS        (COLS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

	// ---- checks ----

	// final hop coincides with the block going idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_hop |-> !busy)
		else $error("last hop shown while still busy");

	// intermediate hops only while a route is in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_hop |-> busy)
		else $error("non-final hop while idle");

	// every hop was produced by a walk step the cycle before
	a_hop_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("hop without an active route");

	// an east hop moves exactly one column right on the same row
	a_east_geom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hop_dir == DIR_E |->
			result.to_col == result.from_col + 3'd1 &&
			result.to_row == result.from_row)
		else $error("east hop geometry wrong");

endmodule

[tb/mesh_route_hop_generator_test.sv]
// ============================================================================
// mesh_route_hop_generator_test - self-checking bench for the hop generator
// Drives weight writes and route requests with random gaps or in bursts, predicts every hop
// from a private copy of the link weights and routing mode, and checks each
// strobed hop, field by field, against the oldest hop still expected.
// ============================================================================
`timescale 1ns / 1ps

module mesh_route_hop_generator_test;
	import mrh_pkg::*;

	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 56;
	// longest adaptive route is 14 hops
	localparam int SETTLE_CYCLES = 32;

	// ------------------------------------------------------------------------
	// Hop predictor and scoreboard
	// Keeps its own weight table and mode; each accepted route is expanded
	// into the hop list the block should strobe, in order.
	// ------------------------------------------------------------------------
	class route_hop_model;
		logic [15:0] weights [256];
		logic [1:0]  mode;
		mrh_hop_t    hops_due [$];
		int          errors;

		function new();
			foreach (weights[i]) weights[i] = '0;
			mode   = MODE_XY;
			errors = 0;
		endfunction

		function int link_idx(int r, int c, logic [1:0] dir);
			return (r * 8 + c) * 4 + dir;
		endfunction

		function void set_mode(logic [1:0] m);
			mode = m;
		endfunction

		function int pending();
			return hops_due.size();
		endfunction

		function void add_hop(int r, int c, logic [1:0] dir, logic [15:0] pen);
			mrh_hop_t h;
			int tr;
			int tc;
			tr = r;
			tc = c;
			case (dir)
				DIR_N: tr = r - 1;
				DIR_S: tr = r + 1;
				DIR_E: tc = c + 1;
				default: tc = c - 1;
			endcase
			h.from_row    = r[2:0];
			h.from_col    = c[2:0];
			h.to_row      = tr[2:0];
			h.to_col      = tc[2:0];
			h.hop_dir     = dir;
			h.hop_penalty = pen;
			h.last_hop    = 1'b0;
			hops_due.push_back(h);
		endfunction

		function void walk_cols(int r, inout int c, input int tc, logic [15:0] pen);
			while (c > tc) begin
				add_hop(r, c, DIR_W, pen);
				c--;
			end
			while (c < tc) begin
				add_hop(r, c, DIR_E, pen);
				c++;
			end
		endfunction

		function void walk_rows(inout int r, input int c, int tr, logic [15:0] pen);
			while (r > tr) begin
				add_hop(r, c, DIR_N, pen);
				r--;
			end
			while (r < tr) begin
				add_hop(r, c, DIR_S, pen);
				r++;
			end
		endfunction

		// Step toward the target; where both axes still shorten the route,
		// the column link wins unless it is strictly heavier.
		function void walk_adaptive(int r, int c, int tr, int tc);
			logic [1:0] xdir;
			logic [1:0] ydir;
			logic [1:0] d;
			xdir = (tc >= c) ? DIR_E : DIR_W;
			ydir = (tr >= r) ? DIR_S : DIR_N;
			while (r != tr || c != tc) begin
				if (c != tc && r != tr)
					d = (weights[link_idx(r, c, xdir)] <= weights[link_idx(r, c, ydir)])
						? xdir : ydir;
				else if (c != tc)
					d = xdir;
				else
					d = ydir;
				add_hop(r, c, d, 16'd0);
				case (d)
					DIR_N: r--;
					DIR_S: r++;
					DIR_E: c++;
					default: c--;
				endcase
			end
		endfunction

		function void note_item(mrh_req_t q);
			int  sr, sc, dr, dc, ax, ay, before_n;
			bit  cols_first;
			mrh_hop_t h;
			if (q.operation == OP_WRITE) begin
				weights[link_idx(q.src_row, q.src_col, q.link_dir)] = q.link_weight;
				return;
			end
			sr = q.src_row;
			sc = q.src_col;
			dr = q.dst_row;
			dc = q.dst_col;
			if (sr == dr && sc == dc)
				return;
			before_n = hops_due.size();
			if (mode == MODE_ADP) begin
				walk_adaptive(sr, sc, dr, dc);
			end else begin
				ax = (sc >= dc) ? sc - dc : dc - sc;
				ay = (sr >= dr) ? sr - dr : dr - sr;
				if (mode == MODE_XY)       cols_first = 1'b1;
				else if (mode == MODE_YX)  cols_first = 1'b0;
				else if (ax == 0)          cols_first = 1'b1;
				else if (ay == 0)          cols_first = 1'b0;
				else if (ax > ay)          cols_first = 1'b0;
				else if (ax < ay)          cols_first = 1'b1;
				else                       cols_first = (ax % 2 == 0);
				if (cols_first) begin
					walk_cols(sr, sc, dc, q.penalty);
					walk_rows(sr, sc, dr, q.penalty);
				end else begin
					walk_rows(sr, sc, dr, q.penalty);
					walk_cols(sr, sc, dc, q.penalty);
				end
			end
			if (hops_due.size() > before_n) begin
				h = hops_due.pop_back();
				h.last_hop = 1'b1;
				hops_due.push_back(h);
			end
		endfunction

		function void check_hop(mrh_hop_t got);
			mrh_hop_t want;
			if (hops_due.size() == 0) begin
				$error("hop strobed with none expected: %p", got);
				errors++;
				return;
			end
			want = hops_due.pop_front();
			if (got.from_row !== want.from_row) begin
				$error("from_row: expected %0d, got %0d", want.from_row, got.from_row);
				errors++;
			end
			if (got.from_col !== want.from_col) begin
				$error("from_col: expected %0d, got %0d", want.from_col, got.from_col);
				errors++;
			end
			if (got.to_row !== want.to_row) begin
				$error("to_row: expected %0d, got %0d", want.to_row, got.to_row);
				errors++;
			end
			if (got.to_col !== want.to_col) begin
				$error("to_col: expected %0d, got %0d", want.to_col, got.to_col);
				errors++;
			end
			if (got.hop_dir !== want.hop_dir) begin
				$error("hop_dir: expected %0d, got %0d", want.hop_dir, got.hop_dir);
				errors++;
			end
			if (got.hop_penalty !== want.hop_penalty) begin
				$error("hop_penalty: expected %0d, got %0d", want.hop_penalty,
					got.hop_penalty);
				errors++;
			end
			if (got.last_hop !== want.last_hop) begin
				$error("last_hop: expected %0d, got %0d", want.last_hop, got.last_hop);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input is known from time zero
	// ------------------------------------------------------------------------
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	mrh_req_t   req       = '0;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = MODE_XY;
	logic       result_valid;
	mrh_hop_t   result;

	route_hop_model route_model = new();
	bit             burst;

	mesh_route_hop_generator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, before the driver's
	// nonblocking updates land, so it sees exactly what the block sees.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				route_model.set_mode(cfg_wdata);
			if (start && !busy)
				route_model.note_item(req);
			if (result_valid)
				route_model.check_hop(result);
		end
	end

	// ------------------------------------------------------------------------
	// Item builders: the fields the operation ignores still get random bits
	// ------------------------------------------------------------------------
	function automatic mrh_req_t route_req(int sr, int sc, int dr, int dc,
			logic [15:0] pen);
		mrh_req_t q;
		q.operation   = OP_ROUTE;
		q.src_row     = sr[2:0];
		q.src_col     = sc[2:0];
		q.dst_row     = dr[2:0];
		q.dst_col     = dc[2:0];
		q.penalty     = pen;
		q.link_dir    = 2'($urandom_range(0, 3));
		q.link_weight = 16'($urandom_range(0, 65535));
		return q;
	endfunction

	function automatic mrh_req_t weight_req(int r, int c, logic [1:0] dir,
			logic [15:0] w);
		mrh_req_t q;
		q.operation   = OP_WRITE;
		q.src_row     = r[2:0];
		q.src_col     = c[2:0];
		q.dst_row     = 3'($urandom_range(0, 7));
		q.dst_col     = 3'($urandom_range(0, 7));
		q.penalty     = 16'($urandom_range(0, 65535));
		q.link_dir    = dir;
		q.link_weight = w;
		return q;
	endfunction

	// ------------------------------------------------------------------------
	// Driver tasks. Each call starts in the time step of the previous
	// acceptance, so start is either kept high (no gap) or dropped once here,
	// never dropped and raised in the same step.
	// ------------------------------------------------------------------------
	task automatic send(mrh_req_t q);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= q;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted hop has been strobed and the block is idle.
	// It waits on the clock first, so the monitor has noted the last accepted item.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (route_model.pending() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		drain();
		// a trailing write or same-node route may still be finishing
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_directed();
		write_mode(MODE_XY);
		send(route_req(0, 0, 7, 7, 16'hFFFF));   // corner to corner, max penalty
		send(route_req(7, 7, 0, 0, 16'h0000));
		send(route_req(3, 4, 3, 4, 16'h1234));   // same node: no hops
		send(route_req(5, 2, 5, 6, 16'h1234));   // columns only
		write_mode(MODE_YX);
		send(route_req(0, 7, 7, 0, 16'hAAAA));
		send(route_req(6, 1, 2, 5, 16'h5555));
		write_mode(MODE_BAL);
		send(route_req(2, 2, 5, 2, 16'h0001));   // no column distance
		send(route_req(4, 1, 4, 6, 16'h0002));   // no row distance
		send(route_req(0, 0, 2, 6, 16'h0003));   // columns farther
		send(route_req(0, 0, 6, 2, 16'h0004));   // rows farther
		send(route_req(1, 1, 3, 3, 16'h0005));   // equal, even
		send(route_req(1, 1, 4, 4, 16'h0006));   // equal, odd
		// weights for the adaptive checks, plus the off-mesh links N of (0,0) and S of (7,7), never used
		send(weight_req(0, 0, DIR_E, 16'hFFFF));
		send(weight_req(0, 0, DIR_S, 16'h0000));
		send(weight_req(0, 0, DIR_N, 16'hFFFF));
		send(weight_req(7, 7, DIR_S, 16'hFFFF));
		send(weight_req(3, 3, DIR_W, 16'h8000));
		write_mode(MODE_ADP);
		send(route_req(0, 0, 2, 2, 16'hFFFF));   // heavy east link, then a tie
		send(route_req(7, 7, 0, 0, 16'hFFFF));   // penalty must not show
		send(route_req(3, 3, 0, 0, 16'h0000));   // heavy west link: go north
		send(route_req(4, 4, 4, 0, 16'h0000));   // one axis only
		send(route_req(2, 5, 2, 5, 16'h0000));
	endtask

	// Mostly routes; writes keep weights small so ties are common
	task automatic run_random(int n);
		int sr, sc;
		for (int i = 0; i < n; i++) begin
			sr = $urandom_range(0, 7);
			sc = $urandom_range(0, 7);
			if ($urandom_range(0, 9) < 3)
				send(weight_req(sr, sc, 2'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 3))));
			else if ($urandom_range(0, 15) == 0)
				send(route_req(sr, sc, sr, sc, 16'($urandom_range(0, 65535))));
			else
				send(route_req(sr, sc, $urandom_range(0, 7), $urandom_range(0, 7),
					16'($urandom_range(0, 65535))));
			// at most one mid-phase pause, taken at random, with nothing in flight
			if (i == n / 2 && $urandom_range(0, 1) == 0)
				drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [1:0] phase_mode [RAND_PHASES];
		phase_mode = '{MODE_ADP, MODE_XY, MODE_BAL, MODE_YX, MODE_ADP,
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), MODE_BAL};
		burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass holds busy high after reset
		do @(posedge clk); while (busy);

		run_directed();
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_mode(phase_mode[p]);
			burst = (p % 3 == 1);
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (route_model.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
